/* src/dtf_pkg.sv */
`timescale 1ns / 1ps

package dtf_pkg;

    // Pipeline depth: registers between the input and the output ports.
    localparam int unsigned NSTG = 9;

    localparam int unsigned TICK_RATE = 50;

    // Field widths.
    localparam int unsigned DAY_W   = 16;
    localparam int unsigned MIN_W   = 11;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned TZ_W    = 18;
    localparam int unsigned SEC_W   = 32;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned CS_W    = 7;

    // Internal widths.
    localparam int unsigned DAYS_W       = 16;
    localparam int unsigned YEAR_W       = 8;
    localparam int unsigned YEAR_FIELD_W = 7;
    localparam int unsigned MONTH_W      = 4;
    localparam int unsigned DOM_W        = 5;
    localparam int unsigned DOY_W        = 9;
    localparam int unsigned DOY_CALC_W   = DAYS_W + 1;
    localparam int unsigned HOUR_W       = 5;
    localparam int unsigned MINUTE_W     = 6;
    localparam int unsigned TWOSEC_W     = 5;
    localparam int unsigned REM_W        = 17;
    localparam int unsigned REM2_W       = 12;
    localparam int unsigned MPROD_W      = MIN_W + 6;

    localparam longint unsigned SECS_PER_MIN  = 60;
    localparam longint unsigned SECS_PER_HOUR = 3600;
    localparam longint unsigned SECS_PER_DAY  = 86400;
    localparam longint unsigned EPOCH_SHIFT   = 63072000;
    localparam longint unsigned BASE_YEAR     = 1980;
    localparam longint unsigned DAYS_PER_YEAR = 365;
    localparam longint unsigned DAYS_4Y       = 4 * 365 + 1;
    localparam longint unsigned CS_ODD        = 100;

    localparam int unsigned LB_W = $clog2(BASE_YEAR + 2 ** YEAR_W);

    localparam int unsigned MONTHS  = 12;
    localparam int unsigned FEBRUARY = 2;
    localparam int unsigned MARCH    = 3;

    // Division by constants as multiplication by a rounded-up reciprocal.
    // The shift is chosen so that the rounding error never reaches the
    // next integer over the whole range of the dividend.

    // tick / TICK_RATE
    localparam int unsigned TQ_W = $clog2((2 ** TICK_W - 1) / TICK_RATE + 1);
    localparam int unsigned TQ_SH = TICK_W + $clog2(TICK_RATE);
    localparam longint unsigned TQ_RCP =
        ((64'd1 << TQ_SH) + TICK_RATE - 1) / TICK_RATE;
    localparam int unsigned TQ_RCP_W = $clog2(TQ_RCP + 1);

    // seconds / 86400, done as (seconds >> 7) / 675
    localparam int unsigned DQ_PRE = 7;
    localparam longint unsigned DQ_DIV = SECS_PER_DAY >> DQ_PRE;
    localparam int unsigned DQ_X_W = SEC_W - DQ_PRE;
    localparam int unsigned DQ_SH = DQ_X_W + $clog2(DQ_DIV);
    localparam longint unsigned DQ_RCP = ((64'd1 << DQ_SH) + DQ_DIV - 1) / DQ_DIV;
    localparam int unsigned DQ_RCP_W = $clog2(DQ_RCP + 1);

    // (4 * days) / 1461
    localparam int unsigned YQ_X_W = DAYS_W + 2;
    localparam int unsigned YQ_SH = YQ_X_W + $clog2(DAYS_4Y);
    localparam longint unsigned YQ_RCP = ((64'd1 << YQ_SH) + DAYS_4Y - 1) / DAYS_4Y;
    localparam int unsigned YQ_RCP_W = $clog2(YQ_RCP + 1);

    // remainder of day / 3600
    localparam int unsigned HQ_SH = REM_W + $clog2(SECS_PER_HOUR);
    localparam longint unsigned HQ_RCP =
        ((64'd1 << HQ_SH) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;
    localparam int unsigned HQ_RCP_W = $clog2(HQ_RCP + 1);

    // remainder of hour / 60
    localparam int unsigned MQ_SH = REM2_W + $clog2(SECS_PER_MIN);
    localparam longint unsigned MQ_RCP =
        ((64'd1 << MQ_SH) + SECS_PER_MIN - 1) / SECS_PER_MIN;
    localparam int unsigned MQ_RCP_W = $clog2(MQ_RCP + 1);

    // Day of year on which each month starts, ignoring the leap day.
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] v;
        case (m)
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/dtf_ctl.sv */
`timescale 1ns / 1ps

module dtf_ctl import dtf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [NSTG-1:0] o_en
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_rdy;
    logic [NSTG-1:0] w_vin;

    // A stage may load when it is empty or when the stage after it moves on,
    // so bubbles are squeezed out even while the output is held.
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_vin = {r_vld[NSTG-2:0], i_valid};
    assign n_vld = (w_rdy & w_vin) | (~w_rdy & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_en    = w_rdy;
    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NSTG-1];

endmodule

/* src/dtf_sec.sv */
`timescale 1ns / 1ps

module dtf_sec import dtf_pkg::*; (
    input  logic                   i_clk,
    input  logic [NSTG-1:0]        i_en,
    input  logic [DAY_W-1:0]       i_day_count,
    input  logic [MIN_W-1:0]       i_minute_of_day,
    input  logic [TICK_W-1:0]      i_tick_of_minute,
    input  logic signed [TZ_W-1:0] i_tz,
    input  logic [SEC_W-1:0]       i_shift,
    output logic [SEC_W-1:0]       o_secs,
    output logic [DAYS_W-1:0]      o_days
);

    localparam int unsigned TQ_PW = TICK_W + TQ_RCP_W;
    localparam int unsigned DQ_PW = DQ_X_W + DQ_RCP_W;

    logic [TQ_PW-1:0]   w_tq_prod;
    logic [SEC_W-1:0]   w_day_prod;
    logic [MPROD_W-1:0] w_min_prod;
    logic [SEC_W-1:0]   w_tz_ext;
    logic [SEC_W:0]     w_diff;
    logic [DQ_PW-1:0]   w_dq_prod;

    logic [SEC_W-1:0]   r1_dprod;
    logic [MPROD_W-1:0] r1_mprod;
    logic [TQ_W-1:0]    r1_tq;
    logic [SEC_W-1:0]   r2_sum;
    logic [SEC_W-1:0]   r3_secs;
    logic [SEC_W-1:0]   r4_secs;
    logic [DAYS_W-1:0]  r4_days;

    assign w_tq_prod  = TQ_PW'(i_tick_of_minute) * TQ_PW'(TQ_RCP);
    assign w_day_prod = SEC_W'(i_day_count) * SEC_W'(SECS_PER_DAY);
    assign w_min_prod = MPROD_W'(i_minute_of_day) * MPROD_W'(SECS_PER_MIN);

    assign w_tz_ext = {{(SEC_W - TZ_W){i_tz[TZ_W-1]}}, i_tz};

    // A borrow means the seconds lie before the 1980 threshold: clamp to it.
    assign w_diff = {1'b0, r2_sum} - {1'b0, i_shift};

    assign w_dq_prod = DQ_PW'(r3_secs[SEC_W-1:DQ_PRE]) * DQ_PW'(DQ_RCP);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_dprod <= w_day_prod;
            r1_mprod <= w_min_prod;
            r1_tq    <= w_tq_prod[TQ_SH +: TQ_W];
        end
        if (i_en[1]) begin
            r2_sum <= r1_dprod + SEC_W'(r1_mprod) + SEC_W'(r1_tq) + w_tz_ext;
        end
        if (i_en[2]) begin
            r3_secs <= w_diff[SEC_W] ? '0 : w_diff[SEC_W-1:0];
        end
        if (i_en[3]) begin
            r4_secs <= r3_secs;
            r4_days <= w_dq_prod[DQ_SH +: DAYS_W];
        end
    end

    assign o_secs = r4_secs;
    assign o_days = r4_days;

endmodule

/* src/dtf_cal.sv */
`timescale 1ns / 1ps

module dtf_cal import dtf_pkg::*; (
    input  logic               i_clk,
    input  logic [NSTG-1:0]    i_en,
    input  logic [DAYS_W-1:0]  i_days,
    output logic [WORD_W-1:0]  o_date_word,
    output logic               o_year_overflow
);

    localparam int unsigned YQ_PW = YQ_X_W + YQ_RCP_W;

    logic [YQ_PW-1:0]      w_yq_prod;
    logic [LB_W-1:0]       w_lb;
    logic [LB_W-1:0]       w_leaps;
    logic [DOY_CALC_W-1:0] w_doy;
    logic [1:0]            w_ymod;
    logic [MONTH_W-1:0]    w_month;
    logic                  w_lsub;
    logic [DOY_W-1:0]      w_day;

    logic [DAYS_W-1:0]     r5_days;
    logic [YEAR_W-1:0]     r5_year;
    logic [DOY_W-1:0]      r6_doy;
    logic                  r6_leap;
    logic [YEAR_W-1:0]     r6_year;
    logic [DOY_W-1:0]      r7_doy;
    logic                  r7_leap;
    logic [YEAR_W-1:0]     r7_year;
    logic [MONTH_W-1:0]    r7_month;
    logic [DOM_W-1:0]      r8_day;
    logic [MONTH_W-1:0]    r8_month;
    logic [YEAR_W-1:0]     r8_year;
    logic [WORD_W-1:0]     r9_date;
    logic                  r9_ovf;

    assign w_yq_prod = YQ_PW'({i_days, 2'b00}) * YQ_PW'(YQ_RCP);

    // Leap days in the years before this one, counting every fourth year.
    assign w_lb    = (LB_W'(BASE_YEAR - 1) + LB_W'(r5_year)) >> 2;
    assign w_leaps = w_lb - LB_W'((BASE_YEAR - 1) / 4);
    assign w_doy   = DOY_CALC_W'(r5_days)
                   - DOY_CALC_W'(r5_year) * DOY_CALC_W'(DAYS_PER_YEAR)
                   - DOY_CALC_W'(w_leaps);
    assign w_ymod  = 2'(BASE_YEAR) + r5_year[1:0];

    // The first month whose end lies beyond the day of year wins; December
    // catches everything else.
    always_comb begin
        logic              lday;
        logic              lsub;
        logic [DOY_W:0]    lhs;
        logic [DOY_W:0]    rhs;
        w_month = MONTH_W'(MONTHS);
        for (int m = MONTHS - 1; m >= 1; m--) begin
            lday = r6_leap && (m == FEBRUARY);
            lsub = r6_leap && (m >= MARCH);
            lhs  = {1'b0, r6_doy} - (DOY_W + 1)'(lsub);
            rhs  = (DOY_W + 1)'(month_start(MONTH_W'(m + 1))) + (DOY_W + 1)'(lday);
            if (lhs < rhs) begin
                w_month = MONTH_W'(m);
            end
        end
    end

    assign w_lsub = r7_leap && (r7_month >= MONTH_W'(MARCH));
    assign w_day  = r7_doy - month_start(r7_month) - DOY_W'(w_lsub) + DOY_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_days <= i_days;
            r5_year <= w_yq_prod[YQ_SH +: YEAR_W];
        end
        if (i_en[5]) begin
            r6_doy  <= w_doy[DOY_W-1:0];
            r6_leap <= (w_ymod == 2'd0);
            r6_year <= r5_year;
        end
        if (i_en[6]) begin
            r7_doy   <= r6_doy;
            r7_leap  <= r6_leap;
            r7_year  <= r6_year;
            r7_month <= w_month;
        end
        if (i_en[7]) begin
            r8_day   <= w_day[DOM_W-1:0];
            r8_month <= r7_month;
            r8_year  <= r7_year;
        end
        if (i_en[8]) begin
            r9_date <= {r8_year[YEAR_FIELD_W-1:0], r8_month, r8_day};
            r9_ovf  <= |r8_year[YEAR_W-1:YEAR_FIELD_W];
        end
    end

    assign o_date_word     = r9_date;
    assign o_year_overflow = r9_ovf;

endmodule

/* src/dtf_tod.sv */
`timescale 1ns / 1ps

module dtf_tod import dtf_pkg::*; (
    input  logic              i_clk,
    input  logic [NSTG-1:0]   i_en,
    input  logic [SEC_W-1:0]  i_secs,
    input  logic [DAYS_W-1:0] i_days,
    output logic [WORD_W-1:0] o_time_word,
    output logic [CS_W-1:0]   o_centiseconds
);

    localparam int unsigned HQ_PW = REM_W + HQ_RCP_W;
    localparam int unsigned MQ_PW = REM2_W + MQ_RCP_W;

    logic [REM_W-1:0]    w_dsec;
    logic [HQ_PW-1:0]    w_hq_prod;
    logic [REM_W-1:0]    w_rem2;
    logic [MQ_PW-1:0]    w_mq_prod;
    logic [REM2_W-1:0]   w_sec;

    logic [REM_W-1:0]    r5_rem;
    logic [REM_W-1:0]    r6_rem;
    logic [HOUR_W-1:0]   r6_hour;
    logic [REM2_W-1:0]   r7_rem2;
    logic [HOUR_W-1:0]   r7_hour;
    logic                r7_odd;
    logic [REM2_W-1:0]   r8_rem2;
    logic [HOUR_W-1:0]   r8_hour;
    logic [MINUTE_W-1:0] r8_min;
    logic                r8_odd;
    logic [WORD_W-1:0]   r9_time;
    logic [CS_W-1:0]     r9_cs;

    // Only the low bits matter: the remainder of the day fits in them.
    assign w_dsec    = REM_W'(i_days) * REM_W'(SECS_PER_DAY);
    assign w_hq_prod = HQ_PW'(r5_rem) * HQ_PW'(HQ_RCP);
    assign w_rem2    = r6_rem - REM_W'(r6_hour) * REM_W'(SECS_PER_HOUR);
    assign w_mq_prod = MQ_PW'(r7_rem2) * MQ_PW'(MQ_RCP);
    assign w_sec     = r8_rem2 - REM2_W'(r8_min) * REM2_W'(SECS_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_rem <= i_secs[REM_W-1:0] - w_dsec;
        end
        if (i_en[5]) begin
            r6_rem  <= r5_rem;
            r6_hour <= w_hq_prod[HQ_SH +: HOUR_W];
        end
        if (i_en[6]) begin
            r7_rem2 <= w_rem2[REM2_W-1:0];
            r7_hour <= r6_hour;
            r7_odd  <= r6_rem[0];
        end
        if (i_en[7]) begin
            r8_rem2 <= r7_rem2;
            r8_hour <= r7_hour;
            r8_min  <= w_mq_prod[MQ_SH +: MINUTE_W];
            r8_odd  <= r7_odd;
        end
        if (i_en[8]) begin
            r9_time <= {r8_hour, r8_min, w_sec[TWOSEC_W:1]};
            r9_cs   <= r8_odd ? CS_W'(CS_ODD) : '0;
        end
    end

    assign o_time_word    = r9_time;
    assign o_centiseconds = r9_cs;

endmodule

/* src/datestamp_to_fat_timestamp.sv */
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is not stalled; a stalled
// output holds only the stages that are full, so empty stages behind it keep
// taking items.
// Reset (synchronous, active low) empties the pipeline and sets the
// timezone offset to zero.

module datestamp_to_fat_timestamp import dtf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TZ_W-1:0]    i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [DAY_W-1:0]   i_day_count,
    input  logic [MIN_W-1:0]   i_minute_of_day,
    input  logic [TICK_W-1:0]  i_tick_of_minute,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WORD_W-1:0]  o_date_word,
    output logic [WORD_W-1:0]  o_time_word,
    output logic [CS_W-1:0]    o_centiseconds,
    output logic               o_year_overflow
);

    logic signed [TZ_W-1:0] r_tz;
    logic [SEC_W-1:0]       r_shift;
    logic [SEC_W-1:0]       w_wdata_ext;
    logic [NSTG-1:0]        w_en;
    logic [SEC_W-1:0]       w_secs;
    logic [DAYS_W-1:0]      w_days;

    assign w_wdata_ext = {{(SEC_W - TZ_W){i_cfg_wdata[TZ_W-1]}}, i_cfg_wdata};

    // The 1980 threshold is kept alongside the offset so the clamp stage
    // needs only one subtraction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz    <= '0;
            r_shift <= SEC_W'(EPOCH_SHIFT);
        end else if (i_cfg_we) begin
            r_tz    <= i_cfg_wdata;
            r_shift <= SEC_W'(EPOCH_SHIFT) + w_wdata_ext;
        end
    end

    dtf_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_en    (w_en)
    );

    dtf_sec u_sec (
        .i_clk            (i_clk),
        .i_en             (w_en),
        .i_day_count      (i_day_count),
        .i_minute_of_day  (i_minute_of_day),
        .i_tick_of_minute (i_tick_of_minute),
        .i_tz             (r_tz),
        .i_shift          (r_shift),
        .o_secs           (w_secs),
        .o_days           (w_days)
    );

    dtf_cal u_cal (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_days          (w_days),
        .o_date_word     (o_date_word),
        .o_year_overflow (o_year_overflow)
    );

    dtf_tod u_tod (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_secs         (w_secs),
        .i_days         (w_days),
        .o_time_word    (o_time_word),
        .o_centiseconds (o_centiseconds)
    );

endmodule

/* src/dtf_chk.sv */
`timescale 1ns / 1ps

module dtf_chk import dtf_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic [TZ_W-1:0]   i_cfg_wdata,
    input logic              i_valid,
    input logic              o_stall,
    input logic [DAY_W-1:0]  i_day_count,
    input logic [MIN_W-1:0]  i_minute_of_day,
    input logic [TICK_W-1:0] i_tick_of_minute,
    input logic              o_valid,
    input logic              i_stall,
    input logic [WORD_W-1:0] o_date_word,
    input logic [WORD_W-1:0] o_time_word,
    input logic [CS_W-1:0]   o_centiseconds,
    input logic              o_year_overflow
);

    // Nothing may come out in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown straight after reset");

    // An empty output stage never pushes back on the input.
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the output stage is empty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_date_word)
            && $stable(o_time_word) && $stable(o_centiseconds)
            && $stable(o_year_overflow))
        else $error("stalled result changed");

    // Month, day, hour, minute and two-second fields stay within a calendar.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_date_word[8:5] != 4'd0) && (o_date_word[8:5] <= 4'd12)
            && (o_date_word[4:0] != 5'd0) && (o_time_word[15:11] <= 5'd23)
            && (o_time_word[10:5] <= 6'd59) && (o_time_word[4:0] <= 5'd29))
        else $error("date or time field out of range");

    a_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_centiseconds == 7'd0) || (o_centiseconds == 7'd100))
        else $error("centiseconds neither 0 nor 100");

endmodule

bind datestamp_to_fat_timestamp dtf_chk u_dtf_chk (.*);

/* verif/dtf_result_checker.sv */
`timescale 1ns / 1ps

module dtf_result_checker import dtf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TZ_W-1:0]   i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [DAY_W-1:0]  i_day_count,
    input  logic [MIN_W-1:0]  i_minute_of_day,
    input  logic [TICK_W-1:0] i_tick_of_minute,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [WORD_W-1:0] i_date_word,
    input  logic [WORD_W-1:0] i_time_word,
    input  logic [CS_W-1:0]   i_centiseconds,
    input  logic              i_year_overflow,
    output int                o_fail_count,
    output int                o_waiting
);

    typedef struct packed {
        logic [WORD_W-1:0] date_word;
        logic [WORD_W-1:0] time_word;
        logic [CS_W-1:0]   centiseconds;
        logic              year_overflow;
    } fat_stamp_t;

    // Start of each month in days, leap day left out; the last entry only
    // bounds December.
    localparam logic [31:0] MONTH_FIRST_DAY [0:13] = '{
        0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
    };

    fat_stamp_t stamps_due_q [$];
    fat_stamp_t want;
    logic [TZ_W-1:0] tz_offset = '0;

    initial begin
        o_fail_count = 0;
        o_waiting    = 0;
    end

    function automatic fat_stamp_t fat_stamp_of(input logic [DAY_W-1:0] day_in,
                                                 input logic [MIN_W-1:0] min_in,
                                                 input logic [TICK_W-1:0] tick_in,
                                                 input logic [TZ_W-1:0] tz_in);
        fat_stamp_t r;
        logic [31:0] tz32, secs, thresh, days, yr, leaps, mon, lday, lsub;
        logic [31:0] hr, mn, twosec;
        logic leap, found;
        tz32 = {{(32 - TZ_W){tz_in[TZ_W-1]}}, tz_in};
        secs = 32'(64'(day_in) * 64'd86400 + 64'(min_in) * 64'd60
                   + 64'(tick_in / TICK_RATE));
        secs = secs + tz32;
        // Anything before 1980 is raised to the epoch itself.
        thresh = 32'd63072000 + tz32;
        if (secs < thresh)
            secs = thresh;
        secs = secs - thresh;

        days  = secs / 32'd86400;
        yr    = (32'd4 * days) / 32'd1461;
        leaps = (32'd1979 + yr) / 32'd4 - 32'd1979 / 32'd4;
        days  = days - (yr * 32'd365 + leaps);
        leap  = ((32'd1980 + yr) % 32'd4) == 32'd0;

        mon   = 32'd12;
        found = 1'b0;
        for (int m = 1; m <= 12; m++) begin
            if (!found) begin
                lday = (leap && m == 2) ? 32'd1 : 32'd0;
                lsub = (leap && m >= 3) ? 32'd1 : 32'd0;
                if (m == 12 || days - lsub < MONTH_FIRST_DAY[m + 1] + lday) begin
                    mon   = 32'(m);
                    days  = days - (MONTH_FIRST_DAY[m] + lsub);
                    found = 1'b1;
                end
            end
        end

        hr     = (secs % 32'd86400) / 32'd3600;
        mn     = (secs % 32'd3600) / 32'd60;
        twosec = (secs % 32'd60) / 32'd2;

        r.date_word     = {yr[6:0], mon[3:0], 5'(days + 32'd1)};
        r.time_word     = {hr[4:0], mn[5:0], twosec[4:0]};
        r.centiseconds  = secs[0] ? 7'd100 : 7'd0;
        r.year_overflow = (yr > 32'd127);
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] exp_val);
        $display("ERROR at %0t ns: %s is %0h, expected %0h", $time, what, got, exp_val);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tz_offset = '0;
            stamps_due_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                stamps_due_q.push_back(fat_stamp_of(i_day_count, i_minute_of_day,
                                                    i_tick_of_minute, tz_offset));
            if (i_cfg_we)
                tz_offset = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (stamps_due_q.size() == 0) begin
                    report("result with no item outstanding, date_word", i_date_word, 0);
                end else begin
                    want = stamps_due_q.pop_front();
                    if (i_date_word !== want.date_word)
                        report("date_word", i_date_word, want.date_word);
                    if (i_time_word !== want.time_word)
                        report("time_word", i_time_word, want.time_word);
                    if (i_centiseconds !== want.centiseconds)
                        report("centiseconds", i_centiseconds, want.centiseconds);
                    if (i_year_overflow !== want.year_overflow)
                        report("year_overflow", i_year_overflow, want.year_overflow);
                end
            end
        end
        o_waiting = stamps_due_q.size();
    end

endmodule

/* verif/tb_datestamp_to_fat_timestamp.sv */
`timescale 1ns / 1ps

module tb_datestamp_to_fat_timestamp;
    import dtf_pkg::*;

    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 250;
    localparam int N_ITEMS      = 25 + PHASES * PHASE_ITEMS;
    localparam int EPOCH_DAY    = 730;
    localparam int YEAR128_DAY  = 47482;
    localparam int WRAP_DAY     = 49710;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MIN_W-1:0]  minute;
        logic [TICK_W-1:0] tick;
    } datestamp_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [TZ_W-1:0]   i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [DAY_W-1:0]  i_day_count = '0;
    logic [MIN_W-1:0]  i_minute_of_day = '0;
    logic [TICK_W-1:0] i_tick_of_minute = '0;
    logic              o_valid;
    logic              i_stall;
    logic [WORD_W-1:0] o_date_word;
    logic [WORD_W-1:0] o_time_word;
    logic [CS_W-1:0]   o_centiseconds;
    logic              o_year_overflow;

    logic burst_stall = 1'b0;
    logic long_hold = 1'b0;
    int   n_fail;
    int   n_waiting;
    int   n_sent = 0;
    int   gap_left = 0;
    int   sink_left = 0;
    logic idle_on;
    datestamp_t stamps_to_send_q [$];
    datestamp_t next_stamp;

    assign i_stall = burst_stall | long_hold;
    assign idle_on = (n_sent < N_ITEMS - 150);

    always #6 i_clk = ~i_clk;

    datestamp_to_fat_timestamp dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_day_count      (i_day_count),
        .i_minute_of_day  (i_minute_of_day),
        .i_tick_of_minute (i_tick_of_minute),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_date_word      (o_date_word),
        .o_time_word      (o_time_word),
        .o_centiseconds   (o_centiseconds),
        .o_year_overflow  (o_year_overflow)
    );

    dtf_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_day_count      (i_day_count),
        .i_minute_of_day  (i_minute_of_day),
        .i_tick_of_minute (i_tick_of_minute),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_date_word      (o_date_word),
        .i_time_word      (o_time_word),
        .i_centiseconds   (o_centiseconds),
        .i_year_overflow  (o_year_overflow),
        .o_fail_count     (n_fail),
        .o_waiting        (n_waiting)
    );

    // Sender: a new item is only put up once the previous one has gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left != 0 && idle_on) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (stamps_to_send_q.size() != 0) begin
                next_stamp = stamps_to_send_q.pop_front();
                i_day_count      <= next_stamp.day;
                i_minute_of_day  <= next_stamp.minute;
                i_tick_of_minute <= next_stamp.tick;
                i_valid          <= 1'b1;
                n_sent++;
                if (idle_on && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 17);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure in bursts, with the odd long free stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            burst_stall <= 1'b0;
            sink_left = 0;
        end else if (!idle_on) begin
            burst_stall <= 1'b0;
            sink_left = 0;
        end else if (sink_left != 0) begin
            sink_left--;
        end else if ($urandom_range(0, 9) == 0) begin
            burst_stall <= 1'b0;
            sink_left = 60;
        end else begin
            burst_stall <= ($urandom_range(0, 2) == 0);
            sink_left = $urandom_range(0, 16);
        end
    end

    // One long hold-off early on, so that the pipeline fills and stalls its input.
    initial begin
        wait (n_sent >= 60);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (240) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAIL datestamp_to_fat_timestamp");
        $finish;
    end

    task automatic push_stamp(input int d, input int m, input int t);
        datestamp_t s;
        s.day    = d[DAY_W-1:0];
        s.minute = m[MIN_W-1:0];
        s.tick   = t[TICK_W-1:0];
        stamps_to_send_q.push_back(s);
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (stamps_to_send_q.size() != 0 || i_valid || n_waiting != 0);
    endtask

    task automatic write_timezone(input int tz);
        wait_drained();
        repeat (12) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= tz[TZ_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_random_stamp();
        int sel;
        int d;
        int offs [14] = '{0, 30, 31, 58, 59, 60, 364, 365, 366, 730, 731, 1095, 1096, 1460};
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1:
                push_stamp($urandom_range(0, 65535), $urandom_range(0, 2047),
                           $urandom_range(0, 65535));
            2:
                push_stamp(EPOCH_DAY - 2 + $urandom_range(0, 4), $urandom_range(0, 1439),
                           $urandom_range(0, 2999));
            3, 4: begin
                d = EPOCH_DAY + 1461 * $urandom_range(0, 33) + offs[$urandom_range(0, 13)];
                push_stamp(d, $urandom_range(0, 1439), $urandom_range(0, 2999));
            end
            5:
                push_stamp(YEAR128_DAY - 400 + $urandom_range(0, 800), $urandom_range(0, 1439),
                           $urandom_range(0, 2999));
            6:
                push_stamp(WRAP_DAY - 3 + $urandom_range(0, 6), $urandom_range(0, 1439),
                           $urandom_range(0, 2999));
            default:
                push_stamp($urandom_range(0, 65535), $urandom_range(0, 1439),
                           $urandom_range(0, 2999));
        endcase
    endtask

    initial begin
        int plan [PHASES] = '{86400, -86400, -1, 19800, 0, 0, 0};
        int tz;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_timezone(0);

        // Directed items: field extremes, the epoch, leap day, year ends,
        // year overflow and the 32-bit wrap of the seconds count.
        push_stamp(0, 0, 0);
        push_stamp(65535, 2047, 65535);
        push_stamp(EPOCH_DAY - 1, 1439, 2999);
        push_stamp(EPOCH_DAY, 0, 0);
        push_stamp(EPOCH_DAY, 0, 50);
        push_stamp(EPOCH_DAY, 0, 49);
        push_stamp(EPOCH_DAY, 1439, 2999);
        push_stamp(EPOCH_DAY + 58, 720, 1500);
        push_stamp(EPOCH_DAY + 59, 0, 0);
        push_stamp(EPOCH_DAY + 60, 0, 0);
        push_stamp(EPOCH_DAY + 365, 1439, 2950);
        push_stamp(EPOCH_DAY + 366, 0, 0);
        push_stamp(EPOCH_DAY + 366 + 59, 0, 0);
        push_stamp(EPOCH_DAY + 1461 + 59, 600, 100);
        push_stamp(YEAR128_DAY - 1, 1439, 2999);
        push_stamp(YEAR128_DAY, 0, 0);
        push_stamp(YEAR128_DAY + 1, 61, 51);
        push_stamp(WRAP_DAY, 0, 0);
        push_stamp(WRAP_DAY, 1439, 2999);
        push_stamp(WRAP_DAY + 1, 0, 0);
        push_stamp(1000, 2047, 0);
        push_stamp(1000, 0, 65535);
        push_stamp(32768, 1024, 32768);
        push_stamp(65535, 1439, 2999);
        push_stamp(21845, 1365, 21845);

        for (int p = 0; p < PHASES; p++) begin
            tz = (p == 4 || p == 5) ? int'($urandom_range(0, 172800)) - 86400 : plan[p];
            write_timezone(tz);
            repeat (PHASE_ITEMS) push_random_stamp();
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS datestamp_to_fat_timestamp");
        end else begin
            $display("FAIL datestamp_to_fat_timestamp");
        end
        $finish;
    end

endmodule
